### hw/rtl/cso_pkg.sv
package cso_pkg;

    localparam int PHASE_BITS_DEF      = 32;
    localparam int TABLE_ADDR_BITS_DEF = 10;
    localparam int SAMPLE_BITS_DEF     = 16;
    localparam int SENSOR_BITS_DEF     = 16;

    localparam int STEP_BITS       = 32;
    localparam int FPU_BITS        = 5;
    localparam int COUNT_BITS      = 4;
    localparam int MAX_INTERVAL    = 16;
    localparam int APB_ADDR_BITS   = 4;
    localparam int APB_DATA_BITS   = 32;
    localparam int SAMPLE_BITS_MAX = 24;

    localparam logic [FPU_BITS-1:0]  FRAMES_PER_UPDATE_RST = 5'd2;
    localparam logic [STEP_BITS-1:0] STEP_AT_MIN_FREQ_RST  = 32'd9739155;
    localparam logic [STEP_BITS-1:0] STEP_SPAN_RST         = 32'd87652394;

    // Quarter-wave polynomial coefficients, Q30
    localparam logic [63:0] COEF_A = 64'd1686629713;
    localparam logic [63:0] COEF_B = 64'd693598067;
    localparam logic [63:0] COEF_C = 64'd85569651;
    localparam logic [63:0] COEF_D = 64'd5026902;

    typedef enum logic [1:0] {
        REG_FRAMES_PER_UPDATE = 2'd0,
        REG_STEP_AT_MIN_FREQ  = 2'd1,
        REG_STEP_SPAN         = 2'd2
    } cso_reg_t;

    typedef struct packed {
        logic [FPU_BITS-1:0]  frames_per_update;
        logic [STEP_BITS-1:0] step_at_min_freq;
        logic [STEP_BITS-1:0] step_span;
    } cso_cfg_t;

    // One sine table entry; evaluated at elaboration only
    function automatic logic [SAMPLE_BITS_MAX-1:0] sine_entry(int idx, int addr_bits,
                                                              int sample_bits);
        logic [63:0] quarter;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] k;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] v;
        logic [63:0] m;
        logic [63:0] smax;
        quarter = 64'd1 << (addr_bits - 2);
        q       = 64'(idx) >> (addr_bits - 2);
        r       = 64'(idx) & (quarter - 64'd1);
        k       = q[0] ? (quarter - r) : r;
        x       = k << (30 - (addr_bits - 2));
        x2      = (x * x) >> 30;
        t       = COEF_C - ((x2 * COEF_D) >> 30);
        t       = COEF_B - ((x2 * t) >> 30);
        t       = COEF_A - ((x2 * t) >> 30);
        v       = (x * t) >> 30;
        smax    = (64'd1 << (sample_bits - 1)) - 64'd1;
        m       = (v * smax + (64'd1 << 29)) >> 30;
        if (m > smax)
        begin
            m = smax;
        end
        if (q >= 64'd2)
        begin
            m = 64'd0 - m;
        end
        return m[SAMPLE_BITS_MAX-1:0];
    endfunction

endpackage

### hw/rtl/cso_apb_regs.sv
module cso_apb_regs
    import cso_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output cso_cfg_t                 cfg
);

    logic [FPU_BITS-1:0]  frames_per_update_reg;
    logic [STEP_BITS-1:0] step_at_min_freq_reg;
    logic [STEP_BITS-1:0] step_span_reg;
    logic                 wr_en;
    logic [1:0]           reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[APB_ADDR_BITS-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_per_update_reg <= FRAMES_PER_UPDATE_RST;
            step_at_min_freq_reg  <= STEP_AT_MIN_FREQ_RST;
            step_span_reg         <= STEP_SPAN_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_FRAMES_PER_UPDATE: frames_per_update_reg <= pwdata[FPU_BITS-1:0];
                REG_STEP_AT_MIN_FREQ:  step_at_min_freq_reg  <= pwdata[STEP_BITS-1:0];
                REG_STEP_SPAN:         step_span_reg         <= pwdata[STEP_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_FRAMES_PER_UPDATE: prdata = APB_DATA_BITS'(frames_per_update_reg);
            REG_STEP_AT_MIN_FREQ:  prdata = APB_DATA_BITS'(step_at_min_freq_reg);
            REG_STEP_SPAN:         prdata = APB_DATA_BITS'(step_span_reg);
            default:               prdata = '0;
        endcase
    end

    assign cfg.frames_per_update = frames_per_update_reg;
    assign cfg.step_at_min_freq  = step_at_min_freq_reg;
    assign cfg.step_span         = step_span_reg;

endmodule

### hw/rtl/cso_sine_rom.sv
module cso_sine_rom
    import cso_pkg::*;
#(
    parameter int ADDR_BITS = TABLE_ADDR_BITS_DEF,
    parameter int DATA_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 en,
    input  logic [ADDR_BITS-1:0] addr,
    output logic [DATA_BITS-1:0] rd_data
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [DATA_BITS-1:0] rom [DEPTH];
    logic [DATA_BITS-1:0] rd_data_reg;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_rom
        localparam logic [SAMPLE_BITS_MAX-1:0] ENTRY = sine_entry(i, ADDR_BITS, DATA_BITS);
        assign rom[i] = ENTRY[DATA_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rd_data_reg <= rom[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/controlled_sine_oscillator_top.sv
// Channel   Direction  Handshake                  Payload
// frame     in         frame_valid / frame_stall  freq_sensor, amp_sensor
// sample    out        sample_valid / sample_stall sample
// config    in         APB write, psel+penable    paddr, pwdata (prdata on read)
//
// One frame beat per cycle sustained while sample_stall is low; sample_valid comes from the round stage register.
// Only the frame count and stage three's phase add and held step/gain loop; all else feeds forward.
// Stages: latch, span multiply, step/phase, sine ROM read, gain multiply, round.
// Reset clears valids, phase, frame count and held step/gain; no clearing pass.
// sample_stall fills pipeline bubbles first; frame_stall rises only when all stages hold.
module controlled_sine_oscillator_top
    import cso_pkg::*;
#(
    parameter int PHASE_BITS      = PHASE_BITS_DEF,
    parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF,
    parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
    parameter int SENSOR_BITS     = SENSOR_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    input  logic                     frame_valid,
    output logic                     frame_stall,
    input  logic [SENSOR_BITS-1:0]   freq_sensor,
    input  logic [SENSOR_BITS-1:0]   amp_sensor,
    output logic                     sample_valid,
    input  logic                     sample_stall,
    output logic [SAMPLE_BITS-1:0]   sample
);

    localparam int MAG_BITS       = SAMPLE_BITS - 1;
    localparam int PROD_BITS      = MAG_BITS + SENSOR_BITS;
    localparam int SPAN_PROD_BITS = STEP_BITS + SENSOR_BITS;
    localparam int SUM_BITS       = (PHASE_BITS > STEP_BITS + 1) ? PHASE_BITS : STEP_BITS + 1;
    localparam logic [PROD_BITS:0] ROUND_HALF = (PROD_BITS + 1)'(1) << (SENSOR_BITS - 1);

    cso_cfg_t cfg;

    cso_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Pipeline control
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic out_valid_reg;
    logic en1, en2, en3, en4, en5, en_out;
    logic frame_accept;
    logic phase_move;

    assign en_out = !out_valid_reg || !sample_stall;
    assign en5    = !s5_valid_reg || en_out;
    assign en4    = !s4_valid_reg || en5;
    assign en3    = !s3_valid_reg || en4;
    assign en2    = !s2_valid_reg || en3;
    assign en1    = !s1_valid_reg || en2;

    assign frame_stall  = !en1;
    assign frame_accept = frame_valid && en1;
    assign phase_move   = s2_valid_reg && en3;

    // Frame counter
    logic [COUNT_BITS-1:0] frame_count_reg;
    logic [COUNT_BITS-1:0] frame_count_next;
    logic [FPU_BITS-1:0]   interval;
    logic [FPU_BITS-1:0]   count_inc;

    always_comb
    begin
        if (cfg.frames_per_update == '0)
        begin
            interval = FPU_BITS'(1);
        end
        else if (cfg.frames_per_update > FPU_BITS'(MAX_INTERVAL))
        begin
            interval = FPU_BITS'(MAX_INTERVAL);
        end
        else
        begin
            interval = cfg.frames_per_update;
        end
        count_inc = FPU_BITS'(frame_count_reg) + FPU_BITS'(1);
        // return to zero once the count reaches or passes the interval
        frame_count_next = (count_inc >= interval) ? '0 : count_inc[COUNT_BITS-1:0];
    end

    // Stage payloads
    logic [SENSOR_BITS-1:0]     s1_freq_reg;
    logic [SENSOR_BITS-1:0]     s1_amp_reg;
    logic                       s1_upd_reg;
    logic [STEP_BITS-1:0]       s2_extra_reg;
    logic [SENSOR_BITS-1:0]     s2_amp_reg;
    logic                       s2_upd_reg;
    logic [TABLE_ADDR_BITS-1:0] s3_addr_reg;
    logic [SENSOR_BITS-1:0]     s3_gain_reg;
    logic [SENSOR_BITS-1:0]     s4_gain_reg;
    logic [PROD_BITS-1:0]       s5_prod_reg;
    logic                       s5_neg_reg;
    logic [SAMPLE_BITS-1:0]     sample_reg;

    // Held state
    logic [PHASE_BITS-1:0]  phase_acc_reg;
    logic [PHASE_BITS-1:0]  held_step_reg;
    logic [SENSOR_BITS-1:0] held_gain_reg;

    logic [SPAN_PROD_BITS-1:0] span_prod;
    logic [SUM_BITS-1:0]       new_step_sum;
    logic [PHASE_BITS-1:0]     step_cur;
    logic [SENSOR_BITS-1:0]    gain_cur;
    logic [SAMPLE_BITS-1:0]    rom_data;
    logic [SAMPLE_BITS-1:0]    rom_abs;
    logic [PROD_BITS:0]        rounded;
    logic [SAMPLE_BITS-1:0]    rnd_mag;

    assign span_prod    = SPAN_PROD_BITS'(cfg.step_span) * SPAN_PROD_BITS'(s1_freq_reg);
    assign new_step_sum = SUM_BITS'(cfg.step_at_min_freq) + SUM_BITS'(s2_extra_reg);
    assign step_cur     = s2_upd_reg ? new_step_sum[PHASE_BITS-1:0] : held_step_reg;
    assign gain_cur     = s2_upd_reg ? s2_amp_reg : held_gain_reg;

    cso_sine_rom #(
        .ADDR_BITS (TABLE_ADDR_BITS),
        .DATA_BITS (SAMPLE_BITS)
    ) u_rom (
        .clk     (clk),
        .en      (en4),
        .addr    (s3_addr_reg),
        .rd_data (rom_data)
    );

    assign rom_abs = rom_data[SAMPLE_BITS-1] ? (SAMPLE_BITS'(0) - rom_data) : rom_data;
    assign rounded = (PROD_BITS + 1)'(s5_prod_reg) + ROUND_HALF;
    assign rnd_mag = rounded[PROD_BITS:SENSOR_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            s3_valid_reg    <= 1'b0;
            s4_valid_reg    <= 1'b0;
            s5_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            frame_count_reg <= '0;
            phase_acc_reg   <= '0;
            held_step_reg   <= '0;
            held_gain_reg   <= '0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= frame_valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (en4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (en5)
            begin
                s5_valid_reg <= s4_valid_reg;
            end
            if (en_out)
            begin
                out_valid_reg <= s5_valid_reg;
            end
            if (frame_accept)
            begin
                frame_count_reg <= frame_count_next;
            end
            // advance phase and latch new control values as the beat leaves stage two
            if (phase_move)
            begin
                phase_acc_reg <= phase_acc_reg + step_cur;
                held_step_reg <= step_cur;
                held_gain_reg <= gain_cur;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_freq_reg <= freq_sensor;
            s1_amp_reg  <= amp_sensor;
            s1_upd_reg  <= (frame_count_reg == '0);
        end
        if (en2)
        begin
            s2_extra_reg <= span_prod[SPAN_PROD_BITS-1:SENSOR_BITS];
            s2_amp_reg   <= s1_amp_reg;
            s2_upd_reg   <= s1_upd_reg;
        end
        if (en3)
        begin
            s3_addr_reg <= phase_acc_reg[PHASE_BITS-1 -: TABLE_ADDR_BITS];
            s3_gain_reg <= gain_cur;
        end
        if (en4)
        begin
            s4_gain_reg <= s3_gain_reg;
        end
        if (en5)
        begin
            s5_prod_reg <= PROD_BITS'(rom_abs[MAG_BITS-1:0]) * PROD_BITS'(s4_gain_reg);
            s5_neg_reg  <= rom_data[SAMPLE_BITS-1];
        end
        if (en_out)
        begin
            sample_reg <= s5_neg_reg ? (SAMPLE_BITS'(0) - rnd_mag) : rnd_mag;
        end
    end

    assign sample_valid = out_valid_reg;
    assign sample       = sample_reg;

`ifndef NO_ASSERTIONS
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        frame_stall |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg && s4_valid_reg
                         && s5_valid_reg && out_valid_reg && sample_stall))
        else $error("frame_stall raised with a free pipeline stage");

    a_update_flag: assert property (@(posedge clk) disable iff (!rst_n)
        frame_accept |=> (s1_upd_reg == $past(frame_count_reg == '0)))
        else $error("update flag does not follow frame count");

    a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !phase_move |=> $stable(phase_acc_reg))
        else $error("phase moved without a beat leaving stage two");

    a_step_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(phase_move && s2_upd_reg) |=> $stable(held_step_reg))
        else $error("held step changed outside an update frame");
`endif

endmodule

### tb/controlled_sine_oscillator_top_tb.sv
`timescale 1ns / 100ps

module controlled_sine_oscillator_top_tb;
    import cso_pkg::*;

    localparam int SENS_W     = SENSOR_BITS_DEF;
    localparam int SMP_W      = SAMPLE_BITS_DEF;
    localparam int PH_W       = PHASE_BITS_DEF;
    localparam int TAB_W      = TABLE_ADDR_BITS_DEF;
    localparam int TAB_SIZE   = 1 << TAB_W;
    localparam int QUARTER    = TAB_SIZE / 4;
    localparam int WATCHDOG   = 4000;
    localparam int PHASE_BEATS = 85;
    localparam int N_PHASES   = 8;
    localparam int LATENCY    = 6;

    localparam logic [1:0] REG_UNUSED = 2'd3;

    class sine_scoreboard;
        logic [FPU_BITS-1:0]   frames_per_update;
        logic [STEP_BITS-1:0]  step_at_min;
        logic [STEP_BITS-1:0]  step_span;
        logic [PH_W-1:0]       phase;
        logic [COUNT_BITS-1:0] frame_cnt;
        logic [STEP_BITS-1:0]  held_step;
        logic [SENS_W-1:0]     held_gain;
        logic signed [SMP_W-1:0] wave [TAB_SIZE];
        logic [SMP_W-1:0]      expected_samples [$];
        int frames_seen;
        int samples_checked;
        int mismatches;

        function new();
            longint unsigned x;
            longint unsigned x2;
            longint unsigned t;
            longint unsigned m;
            longint unsigned smax;
            int q;
            int r;
            int k;
            frames_per_update = FRAMES_PER_UPDATE_RST;
            step_at_min       = STEP_AT_MIN_FREQ_RST;
            step_span         = STEP_SPAN_RST;
            phase             = '0;
            frame_cnt         = '0;
            held_step         = '0;
            held_gain         = '0;
            frames_seen       = 0;
            samples_checked   = 0;
            mismatches        = 0;
            smax              = (64'd1 << (SMP_W - 1)) - 64'd1;
            // quarter-wave polynomial in Q30, mirrored and negated per quadrant
            for (int i = 0; i < TAB_SIZE; i++)
            begin
                q  = i / QUARTER;
                r  = i % QUARTER;
                k  = (q % 2 == 1) ? (QUARTER - r) : r;
                x  = longint'(k) << (30 - (TAB_W - 2));
                x2 = (x * x) >> 30;
                t  = COEF_C - ((x2 * COEF_D) >> 30);
                t  = COEF_B - ((x2 * t) >> 30);
                t  = COEF_A - ((x2 * t) >> 30);
                m  = (((x * t) >> 30) * smax + (64'd1 << 29)) >> 30;
                if (m > smax)
                begin
                    m = smax;
                end
                wave[i] = (q >= 2) ? -SMP_W'(m) : SMP_W'(m);
            end
        endfunction

        function void flag(string what, longint unsigned exp_v, longint unsigned act_v);
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("%0t %s: expected %h, got %h", $realtime, what, exp_v, act_v);
            end
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_FRAMES_PER_UPDATE: frames_per_update = value[FPU_BITS-1:0];
                REG_STEP_AT_MIN_FREQ:  step_at_min = value;
                REG_STEP_SPAN:         step_span = value;
                default: ;
            endcase
        endfunction

        function logic [31:0] reg_value(logic [1:0] idx);
            case (idx)
                REG_FRAMES_PER_UPDATE: return 32'(frames_per_update);
                REG_STEP_AT_MIN_FREQ:  return step_at_min;
                REG_STEP_SPAN:         return step_span;
                default:               return '0;
            endcase
        endfunction

        function void note_frame(logic [SENS_W-1:0] freq, logic [SENS_W-1:0] amp);
            logic [FPU_BITS-1:0]       interval;
            logic [STEP_BITS+SENS_W-1:0] extra;
            logic signed [SMP_W-1:0]   tv;
            logic [SMP_W-1:0]          mag;
            logic [31:0]               prod;
            logic [FPU_BITS-1:0]       next_cnt;
            frames_seen++;
            interval = frames_per_update;
            if (interval == 0)
            begin
                interval = 1;
            end
            else if (interval > MAX_INTERVAL)
            begin
                interval = MAX_INTERVAL;
            end
            if (frame_cnt == 0)
            begin
                extra     = ({{SENS_W{1'b0}}, step_span} * {{STEP_BITS{1'b0}}, freq}) >> SENS_W;
                held_step = step_at_min + extra[STEP_BITS-1:0];
                held_gain = amp;
            end
            tv   = wave[phase[PH_W-1 -: TAB_W]];
            mag  = (tv < 0) ? -tv : tv;
            prod = 32'(mag) * 32'(held_gain) + (32'd1 << (SENS_W - 1));
            mag  = prod[SENS_W +: SMP_W];
            expected_samples.push_back((tv < 0) ? -mag : mag);
            phase    = phase + held_step;
            next_cnt = FPU_BITS'(frame_cnt) + 1'b1;
            frame_cnt = (next_cnt >= interval) ? '0 : next_cnt[COUNT_BITS-1:0];
        endfunction

        function void check_sample(logic [SMP_W-1:0] got);
            logic [SMP_W-1:0] want;
            if (expected_samples.size() == 0)
            begin
                flag("sample with none expected", 0, got);
            end
            else
            begin
                want = expected_samples.pop_front();
                samples_checked++;
                if (got !== want)
                begin
                    flag("sample", want, got);
                end
            end
        endfunction
    endclass

    logic                     clk          = 1'b0;
    logic                     rst_n        = 1'b0;
    logic                     psel         = 1'b0;
    logic                     penable      = 1'b0;
    logic                     pwrite       = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr        = '0;
    logic [APB_DATA_BITS-1:0] pwdata       = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;
    logic                     frame_valid  = 1'b0;
    logic                     frame_stall;
    logic [SENS_W-1:0]        freq_sensor  = '0;
    logic [SENS_W-1:0]        amp_sensor   = '0;
    logic                     sample_valid;
    logic                     sample_stall = 1'b0;
    logic [SMP_W-1:0]         sample;

    sine_scoreboard sb = new();
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int quiet_cycles  = 0;
    int settings_used = 1;

    controlled_sine_oscillator_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .frame_valid  (frame_valid),
        .frame_stall  (frame_stall),
        .freq_sensor  (freq_sensor),
        .amp_sensor   (amp_sensor),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        sample_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (frame_valid && !frame_stall)
        begin
            sb.note_frame(freq_sensor, amp_sensor);
        end
        if (sample_valid && !sample_stall)
        begin
            sb.check_sample(sample);
        end
        if ((frame_valid && !frame_stall) || (sample_valid && !sample_stall))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("no beat for %0d cycles", WATCHDOG);
            $display("[controlled_sine_oscillator_top] ERROR");
            $finish;
        end
    end

    // Hold the beat until it is taken; idle beforehand at the sender's rate.
    task automatic send_frame(input logic [SENS_W-1:0] f, input logic [SENS_W-1:0] a);
        while ($urandom_range(99) < send_idle_pct)
        begin
            frame_valid <= 1'b0;
            @(posedge clk);
        end
        frame_valid <= 1'b1;
        freq_sensor <= f;
        amp_sensor  <= a;
        @(posedge clk);
        while (frame_stall)
        begin
            @(posedge clk);
        end
    endtask

    task automatic drain_samples();
        frame_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_samples.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic apb_access(input logic wr, input logic [1:0] idx,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        rdata = prdata;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] rd;
        apb_access(1'b1, idx, value, rd);
        sb.set_reg(idx, value);
        apb_access(1'b0, idx, '0, rd);
        if (idx != REG_UNUSED && rd !== sb.reg_value(idx))
        begin
            sb.flag("register readback", sb.reg_value(idx), rd);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        logic [SENS_W-1:0] corner [8];
        logic [FPU_BITS-1:0] fpu;
        logic [31:0] min_step;
        logic [31:0] span;
        logic [SENS_W-1:0] f;
        logic [SENS_W-1:0] a;
        corner = '{16'h0000, 16'h0001, 16'h7FFF, 16'h8000,
                   16'hFFFE, 16'hFFFF, 16'h5555, 16'hAAAA};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corner pairs under reset register values
        for (int i = 0; i < 24; i++)
        begin
            send_frame(corner[i % 8], corner[(i * 3 + 1) % 8]);
        end
        drain_samples();

        for (int ph = 1; ph <= N_PHASES; ph++)
        begin
            min_step = $urandom();
            span     = $urandom();
            fpu      = FPU_BITS'($urandom_range(1, MAX_INTERVAL));
            case (ph)
                1: begin fpu = 1;  min_step = '0;  span = '1; end
                2: begin fpu = 16; min_step = '1;  span = '1; end
                3: fpu = 0;
                4: fpu = 31;
                5: fpu = 3;
                6: begin fpu = 5;  min_step = '0;  span = '0; end
                default: ;
            endcase
            // junk above the field width must be dropped
            write_reg(REG_FRAMES_PER_UPDATE, ($urandom() & 32'hFFFF_FFE0) | 32'(fpu));
            write_reg(REG_STEP_AT_MIN_FREQ, min_step);
            write_reg(REG_STEP_SPAN, span);
            if (ph == 5)
            begin
                write_reg(REG_UNUSED, $urandom());
            end
            settings_used++;

            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 66; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 66; end
                default: begin send_idle_pct = 15; stall_pct = 15; end
            endcase

            for (int i = 0; i < PHASE_BEATS; i++)
            begin
                f = ($urandom_range(7) == 0) ? corner[$urandom_range(7)]
                                             : SENS_W'($urandom_range(0, 65535));
                a = ($urandom_range(7) == 0) ? corner[$urandom_range(7)]
                                             : SENS_W'($urandom_range(0, 65535));
                send_frame(f, a);
                if ($urandom_range(39) == 0)
                begin
                    drain_samples();
                end
            end
            drain_samples();
        end

        repeat (LATENCY * 3) @(posedge clk);
        if (sb.expected_samples.size() != 0)
        begin
            sb.flag("samples never delivered", sb.expected_samples.size(), 0);
        end

        $display("%0d frames driven, %0d samples checked over %0d register settings",
                 sb.frames_seen, sb.samples_checked, settings_used);
        $display("update intervals 0 to 31 incl. clamps, step extremes, four idle/stall mixes");
        if (sb.mismatches == 0)
        begin
            $display("[controlled_sine_oscillator_top] OK");
        end
        else
        begin
            $display("%0d mismatches", sb.mismatches);
            $display("[controlled_sine_oscillator_top] ERROR");
        end
        $finish;
    end

endmodule
